// ----- hw/rtl/bsm_pkg.sv -----
// Shared constants and types of the 5x5 binomial smoother.
package bsm_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int TAPS      = 5;
	localparam int BANKS     = TAPS - 1;
	localparam int HALF      = TAPS / 2;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	localparam int PIX_W  = 8;
	localparam int HSUM_W = 12;
	localparam int VSUM_W = 16;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 12;
	localparam int FW_W   = 11;
	localparam int FH_W   = 12;
	localparam int WGT_W  = 3;

	localparam int MIN_SIZE     = 6;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [WGT_W-1:0] TAP_W [TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

	// Configuration register indexes.
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// Line store access shared by all cells of the chain.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              clr;
	} mem_ctl_t;

	// One burst of identical result words.
	typedef struct packed {
		logic [PIX_W-1:0] val;
		logic [COL_W-1:0] c0;
		logic [COL_W-1:0] c1;
		logic [ROW_W-1:0] r0;
		logic [ROW_W-1:0] r1;
	} burst_t;

endpackage

// ----- hw/rtl/bsm_cell.sv -----
// One tap cell: a row window pixel, a line store bank and both partial sums.
module bsm_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic [bsm_pkg::PIX_W-1:0]      pix_in,
	output logic [bsm_pkg::PIX_W-1:0]      pix_q,
	input  logic [bsm_pkg::WGT_W-1:0]      weight,
	input  logic [bsm_pkg::HSUM_W-1:0]     hsum_in,
	output logic [bsm_pkg::HSUM_W-1:0]     hsum_out,
	input  bsm_pkg::mem_ctl_t              ctl,
	input  logic [bsm_pkg::HSUM_W-1:0]     wr_data,
	output logic [bsm_pkg::HSUM_W-1:0]     rd_q,
	input  logic [bsm_pkg::VSUM_W-1:0]     vsum_in,
	output logic [bsm_pkg::VSUM_W-1:0]     vsum_out
);
	import bsm_pkg::*;

	logic [HSUM_W-1:0] bank [MAX_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift) begin
			pix_q <= pix_in;
		end
	end

	// The bank takes its neighbor's read of the same column, or zero on clear.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			bank[ctl.wr_addr] <= ctl.clr ? '0 : wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= bank[ctl.rd_addr];
		end
	end

	assign hsum_out = hsum_in + HSUM_W'(pix_q) * HSUM_W'(weight);
	assign vsum_out = vsum_in + VSUM_W'(rd_q) * VSUM_W'(weight);

endmodule

// ----- hw/rtl/bsm_burst.sv -----
// Result sequencer: sends one value for every position of a burst, rows inside columns.
module bsm_burst (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  bsm_pkg::burst_t            burst,
	output logic                       free,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bsm_pkg::PIX_W-1:0]  pixel_out,
	output logic [bsm_pkg::ROW_W-1:0]  out_row,
	output logic [bsm_pkg::COL_W-1:0]  out_col,
	output logic                       last
);
	import bsm_pkg::*;

	logic             busy_q;
	logic [PIX_W-1:0] val_q;
	logic [COL_W-1:0] oc_q;
	logic [COL_W-1:0] c1_q;
	logic [ROW_W-1:0] orow_q;
	logic [ROW_W-1:0] r0_q;
	logic [ROW_W-1:0] r1_q;
	logic             fire;

	assign last      = (orow_q == r1_q) && (oc_q == c1_q);
	assign fire      = busy_q && !out_stall;
	assign free      = !busy_q || (fire && last);
	assign out_valid = busy_q;
	assign pixel_out = val_q;
	assign out_row   = orow_q;
	assign out_col   = oc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (fire && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= burst.val;
			oc_q   <= burst.c0;
			c1_q   <= burst.c1;
			orow_q <= burst.r0;
			r0_q   <= burst.r0;
			r1_q   <= burst.r1;
		end else if (fire && !last) begin
			if (orow_q == r1_q) begin
				oc_q   <= oc_q + 1'b1;
				orow_q <= r0_q;
			end else begin
				orow_q <= orow_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/binomial_smooth_5x5.sv -----
// Top level of the streaming 5x5 binomial smoother with replicated borders.
//
//  channel  direction  handshake            word
//  pixel    in         in_valid / in_stall  pixel_in
//  result   out        out_valid/out_stall  pixel_out, out_row, out_col, last
//  config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A pixel is taken every cycle unless stalled; its results are registered
// in stage one, then loaded into the burst sequencer. Near the frame edges
// one pixel yields up to nine words, one per cycle while out_stall is low,
// and the pixel input stalls meanwhile. After reset the four line store
// banks are cleared, one column per cycle; no pixel is taken then,
// configuration writes are. The horizontal sum is formed as the pixel
// enters, the vertical one from the registered bank reads in the next cycle.
module binomial_smooth_5x5 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bsm_pkg::PIX_W-1:0]     pixel_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bsm_pkg::PIX_W-1:0]     pixel_out,
	output logic [bsm_pkg::ROW_W-1:0]     out_row,
	output logic [bsm_pkg::COL_W-1:0]     out_col,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bsm_pkg::FH_W-1:0]      cfg_data
);
	import bsm_pkg::*;

	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [COL_W-1:0]  col_count_q;
	logic [ROW_W-1:0]  row_count_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;
	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic             in_accept;
	logic             store_s0;
	logic             emit_s0;
	logic [COL_W-1:0] c0_s0, c1_s0;
	logic [ROW_W-1:0] r0_s0, r1_s0;

	logic              v_s1;
	logic              store_s1;
	logic              emit_s1;
	logic [HSUM_W-1:0] hsum_s1;
	logic [COL_W-1:0]  col_s1;
	logic [COL_W-1:0]  c0_s1, c1_s1;
	logic [ROW_W-1:0]  r0_s1, r1_s1;
	logic              s1_adv;
	logic              burst_free;
	burst_t            burst;
	mem_ctl_t          ctl;

	logic [PIX_W-1:0]  pix_w   [BANKS];
	logic [HSUM_W-1:0] rd_w    [BANKS];
	logic [HSUM_W-1:0] wdata_w [BANKS];
	logic [PIX_W-1:0]  pin_w   [BANKS];
	logic [HSUM_W-1:0] hchain  [BANKS+1];
	logic [VSUM_W-1:0] vchain  [BANKS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(RESET_WIDTH);
			frame_height_q <= FH_W'(RESET_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < FW_W'(MIN_SIZE)) begin
			w_eff = FW_W'(MIN_SIZE);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < FH_W'(MIN_SIZE)) begin
			h_eff = FH_W'(MIN_SIZE);
		end else begin
			h_eff = frame_height_q;
		end
	end

	assign wm1 = COL_W'(w_eff - 1'b1);
	assign hm1 = ROW_W'(h_eff - 1'b1);

	assign in_stall  = clr_q || (v_s1 && !s1_adv);
	assign in_accept = in_valid && !in_stall;

	assign store_s0 = (col_count_q >= COL_W'(BANKS)) && (col_count_q <= wm1)
		&& (row_count_q <= hm1);
	assign emit_s0  = store_s0 && (row_count_q >= ROW_W'(BANKS));

	// Edge positions also cover the replicated border pixels.
	always_comb begin
		if (col_count_q == COL_W'(BANKS)) begin
			c0_s0 = '0;
			c1_s0 = COL_W'(HALF);
		end else if (col_count_q == wm1) begin
			c0_s0 = wm1 - COL_W'(HALF);
			c1_s0 = wm1;
		end else begin
			c0_s0 = col_count_q - COL_W'(HALF);
			c1_s0 = c0_s0;
		end
		if (row_count_q == ROW_W'(BANKS)) begin
			r0_s0 = '0;
			r1_s0 = ROW_W'(HALF);
		end else if (row_count_q == hm1) begin
			r0_s0 = hm1 - ROW_W'(HALF);
			r1_s0 = hm1;
		end else begin
			r0_s0 = row_count_q - ROW_W'(HALF);
			r1_s0 = r0_s0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (in_accept) begin
			if (col_count_q >= wm1) begin
				col_count_q <= '0;
				row_count_q <= (row_count_q >= hm1) ? '0 : row_count_q + 1'b1;
			end else begin
				col_count_q <= col_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			store_s1 <= store_s0;
			emit_s1  <= emit_s0;
			hsum_s1  <= hchain[BANKS];
			col_s1   <= col_count_q;
			c0_s1    <= c0_s0;
			c1_s1    <= c1_s0;
			r0_s1    <= r0_s0;
			r1_s1    <= r1_s0;
		end
	end

	// Pixels that yield no result leave stage one at once.
	assign s1_adv = v_s1 && (!emit_s1 || burst_free);

	// The column is written back as the word leaves stage one; the next
	// pixel always reads a different column.
	always_comb begin
		ctl.rd_en   = in_accept;
		ctl.rd_addr = ADDR_W'(col_count_q);
		ctl.wr_en   = clr_q || (s1_adv && store_s1);
		ctl.wr_addr = clr_q ? clr_addr_q : ADDR_W'(col_s1);
		ctl.clr     = clr_q;
	end

	assign hchain[0] = HSUM_W'(pixel_in) * HSUM_W'(TAP_W[TAPS-1]);
	assign vchain[0] = VSUM_W'(hsum_s1) * VSUM_W'(TAP_W[TAPS-1]);

	for (genvar k = 0; k < BANKS; k++) begin : g_cell
		if (k == BANKS - 1) begin : g_end
			assign pin_w[k]   = pixel_in;
			assign wdata_w[k] = hsum_s1;
		end else begin : g_mid
			assign pin_w[k]   = pix_w[k+1];
			assign wdata_w[k] = rd_w[k+1];
		end

		bsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (in_accept),
			.pix_in   (pin_w[k]),
			.pix_q    (pix_w[k]),
			.weight   (TAP_W[k]),
			.hsum_in  (hchain[k]),
			.hsum_out (hchain[k+1]),
			.ctl      (ctl),
			.wr_data  (wdata_w[k]),
			.rd_q     (rd_w[k]),
			.vsum_in  (vchain[k]),
			.vsum_out (vchain[k+1])
		);
	end

	always_comb begin
		burst.val = vchain[BANKS][VSUM_W-1:VSUM_W-PIX_W];
		burst.c0  = c0_s1;
		burst.c1  = c1_s1;
		burst.r0  = r0_s1;
		burst.r1  = r1_s1;
	end

	bsm_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_adv && emit_s1),
		.burst     (burst),
		.free      (burst_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.last      (last)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall)
		else $error("pixel taken during line store clear");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s1_adv && store_s1) |-> (col_count_q != col_s1))
		else $error("line store read and write hit the same column");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("burst ended before its last word");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the streaming 5x5 binomial smoother.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bsm_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} smoothed_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [PIX_W-1:0]    pixel_in  = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PIX_W-1:0]    pixel_out;
	logic [ROW_W-1:0]    out_row;
	logic [COL_W-1:0]    out_col;
	logic                last;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = 1'b0;
	logic [FH_W-1:0]     cfg_data  = '0;

	// Shadow of the block: sizes as written, the row window, the column sums and the position.
	logic [FW_W-1:0]     model_width  = FW_W'(RESET_WIDTH);
	logic [FH_W-1:0]     model_height = FH_W'(RESET_HEIGHT);
	logic [PIX_W-1:0]    px_hist [BANKS];
	logic [HSUM_W-1:0]   hsum_rows [BANKS][MAX_WIDTH];
	int unsigned         col_pos;
	int unsigned         row_pos;

	logic [PIX_W-1:0]    pixel_feed [$];
	smoothed_t           smoothed_q [$];
	int                  pixels_pushed  = 0;
	int                  pixels_taken   = 0;
	int                  mismatches     = 0;
	int                  feed_idle_pct  = 36;
	int                  drain_idle_pct = 36;
	int                  hold_req       = 0;
	int                  hold_seen;
	int                  hold_left;
	int                  quiet_cycles   = 0;

	binomial_smooth_5x5 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Filters one pixel and queues every output pixel whose value it settles.
	function automatic void smooth_pixel(input logic [PIX_W-1:0] px);
		int unsigned w, h, c, r, hsum, vsum, c0, c1, r0, r1, oc, orow;
		logic [PIX_W-1:0] val;
		w = model_width;
		if (w < MIN_SIZE) w = MIN_SIZE;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = model_height;
		if (h < MIN_SIZE) h = MIN_SIZE;
		c = col_pos;
		r = row_pos;
		hsum = TAP_W[BANKS] * px;
		for (int k = 0; k < BANKS; k++) hsum += TAP_W[k] * px_hist[k];
		for (int k = 0; k < BANKS - 1; k++) px_hist[k] = px_hist[k + 1];
		px_hist[BANKS - 1] = px;
		if (c >= BANKS && c < w && c < MAX_WIDTH && r < h) begin
			vsum = TAP_W[BANKS] * hsum;
			for (int k = 0; k < BANKS; k++) vsum += TAP_W[k] * hsum_rows[k][c];
			for (int k = 0; k < BANKS - 1; k++) hsum_rows[k][c] = hsum_rows[k + 1][c];
			hsum_rows[BANKS - 1][c] = hsum[HSUM_W-1:0];
			if (r >= BANKS) begin
				val = vsum[15:8];
				// The first and last filter centers also stand in for the border pixels.
				if (c == BANKS) begin
					c0 = 0;
					c1 = HALF;
				end else if (c == w - 1) begin
					c0 = w - 1 - HALF;
					c1 = w - 1;
				end else begin
					c0 = c - HALF;
					c1 = c0;
				end
				if (r == BANKS) begin
					r0 = 0;
					r1 = HALF;
				end else if (r == h - 1) begin
					r0 = h - 1 - HALF;
					r1 = h - 1;
				end else begin
					r0 = r - HALF;
					r1 = r0;
				end
				for (oc = c0; oc <= c1; oc++) begin
					for (orow = r0; orow <= r1; orow++) begin
						smoothed_q.push_back('{val, ROW_W'(orow), COL_W'(oc),
							(oc == c1 && orow == r1)});
					end
				end
			end
		end
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic feed_pixel(input logic [PIX_W-1:0] px);
		pixel_feed.push_back(px);
		pixels_pushed++;
	endtask

	// Waits until every pixel is taken and every expected word has come, then lets the
	// pipeline run empty, since pixels without a result may still be in flight.
	task automatic settle();
		while (pixels_taken != pixels_pushed || smoothed_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Keeps the write valid high when another write follows at once.
	task automatic write_reg(input logic idx, input logic [FH_W-1:0] value, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (!more) cfg_valid <= 1'b0;
		if (idx == CFG_FRAME_WIDTH) model_width = value[FW_W-1:0];
		else model_height = value;
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_in <= '0;
			col_pos = 0;
			row_pos = 0;
			for (int k = 0; k < BANKS; k++) begin
				px_hist[k] = '0;
				for (int a = 0; a < MAX_WIDTH; a++) hsum_rows[k][a] = '0;
			end
		end else begin
			if (in_valid && !in_stall) begin
				smooth_pixel(pixel_in);
				pixels_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_feed.size() != 0 && $urandom_range(99) >= feed_idle_pct) begin
					in_valid <= 1'b1;
					pixel_in <= pixel_feed.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		smoothed_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (smoothed_q.size() == 0) begin
					$display("%0t: unexpected word pixel_out=%0d row=%0d col=%0d last=%0b",
						$time, pixel_out, out_row, out_col, last);
					mismatches++;
				end else begin
					want = smoothed_q.pop_front();
					check_field("pixel_out", 16'(want.pix), 16'(pixel_out));
					check_field("out_row", 16'(want.row), 16'(out_row));
					check_field("out_col", 16'(want.col), 16'(out_col));
					check_field("last", 16'(want.last), 16'(last));
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < drain_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int fw, fh, n, random_fed;
		bit first_frame;
		fw = 6;
		fh = 6;
		random_fed = 0;
		first_frame = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both sizes below the minimum; the width also carries a stray bit above its field.
		write_reg(CFG_FRAME_WIDTH, 12'h803, 1'b1);
		write_reg(CFG_FRAME_HEIGHT, 12'd2, 1'b0);
		for (n = 0; n < 36; n++) begin
			case (n % 4)
				0: feed_pixel(8'hFF);
				1: feed_pixel(8'h00);
				2: feed_pixel(8'h01 << (n % 8));
				default: feed_pixel(~(8'h01 << (n % 8)));
			endcase
		end
		settle();

		// Shrink the frame under a position that already lies past the new edges.
		// The frame itself runs at full rate on both sides.
		feed_idle_pct = 0;
		drain_idle_pct = 0;
		write_reg(CFG_FRAME_WIDTH, 12'd10, 1'b1);
		write_reg(CFG_FRAME_HEIGHT, 12'd8, 1'b0);
		repeat (6 * 10 + 8) feed_pixel(rand_pixel());
		settle();
		feed_idle_pct = 36;
		drain_idle_pct = 36;
		write_reg(CFG_FRAME_WIDTH, 12'd6, 1'b0);
		feed_pixel(rand_pixel());
		settle();
		write_reg(CFG_FRAME_HEIGHT, 12'd6, 1'b0);
		repeat (6) feed_pixel(rand_pixel());
		settle();

		// Small random frames; the first is fed whole while the receiver holds off,
		// later ones may be cut short or follow without a pause.
		while (random_fed < 40) begin
			if (first_frame || $urandom_range(99) < 70) begin
				fw = $urandom_range(10, 6);
				fh = $urandom_range(8, 6);
				settle();
				write_reg(CFG_FRAME_WIDTH, FH_W'(fw), 1'b1);
				write_reg(CFG_FRAME_HEIGHT, FH_W'(fh), 1'b0);
			end
			n = fw * fh;
			if (!first_frame && $urandom_range(99) < 25) n = $urandom_range(n - 1, 1);
			repeat (n) feed_pixel(rand_pixel());
			random_fed += n;
			if (first_frame) hold_req <= hold_req + 1;
			first_frame = 1'b0;
		end
		settle();

		// Finish any frame left open, one pixel at a time.
		write_reg(CFG_FRAME_WIDTH, 12'd6, 1'b1);
		write_reg(CFG_FRAME_HEIGHT, 12'd6, 1'b0);
		while (col_pos != 0 || row_pos != 0) begin
			feed_pixel(rand_pixel());
			settle();
		end

		if (mismatches == 0 && smoothed_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_cell.sv
hw/rtl/bsm_burst.sv
hw/rtl/binomial_smooth_5x5.sv
bench/tb_top.sv
